@@ hw/rtl/rclh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclh_pkg
// Shared types and constants for the remote-control link sequencer: event
// and command payloads, configuration set, phase codes and radio constants.
// ----------------------------------------------------------------------------
package rclh_pkg;

  // Event payload: timer expiry with radio status and received header.
  typedef struct packed {
    logic        tx_done;
    logic [7:0]  rx_irq_status;
    logic [7:0]  rx_length;
    logic [7:0]  rx_count;
    logic [7:0]  rx_type;
    logic [47:0] rx_id;
  } evt_item_t;

  // Command payload: one radio command.
  typedef struct packed {
    logic        set_channel;
    logic [6:0]  rf_channel;
    logic [1:0]  radio_mode;
    logic [1:0]  send_kind;
    logic        refresh_data;
    logic        load_link;
    logic [4:0]  sop_index;
    logic [15:0] crc_seed;
    logic [14:0] next_delay_us;
  } cmd_item_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [47:0] device_id;
    logic [6:0]  hop_channel_a;
    logic [6:0]  hop_channel_b;
    logic [6:0]  hop_channel_c;
  } cfg_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_DEVICE_ID = 2'd0,
    REG_HOP_A     = 2'd1,
    REG_HOP_B     = 2'd2,
    REG_HOP_C     = 2'd3
  } reg_index_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_BIND_START = 4'd0,
    PH_BIND_SEND  = 4'd1,
    PH_WAIT_TX    = 4'd2,
    PH_CHECK      = 4'd3,
    PH_ACK0       = 4'd4,
    PH_ACK1       = 4'd5,
    PH_ACK2       = 4'd6,
    PH_ACK3       = 4'd7,
    PH_ACK4       = 4'd8,
    PH_ACK5       = 4'd9,
    PH_LINK       = 4'd10,
    PH_HOP0       = 4'd11,
    PH_HOP1       = 4'd12,
    PH_HOP2       = 4'd13,
    PH_HOP3       = 4'd14,
    PH_SPARE      = 4'd15
  } phase_t;

  // Radio mode codes.
  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TX   = 2'd2;

  // Packet kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BIND = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  // Bind channels.
  localparam logic [6:0] CH_BIND_TX = 7'h52;
  localparam logic [6:0] CH_BIND_RX = 7'h53;
  localparam logic [6:0] CH_ACK     = 7'h54;

  // Reply check values.
  localparam logic [7:0] RX_STATUS_MASK = 8'h1a;
  localparam logic [7:0] RX_BIND_LEN    = 8'h0f;
  localparam logic [7:0] RX_BIND_TYPE   = 8'h03;

  // Delays in microseconds.
  localparam logic [14:0] DLY_BIND_TX = 15'd3000;
  localparam logic [14:0] DLY_LISTEN  = 15'd30000;
  localparam logic [14:0] DLY_ACK_GO  = 15'd2000;
  localparam logic [14:0] DLY_RETRY   = 15'd500;
  localparam logic [14:0] DLY_ACK     = 15'd4600;
  localparam logic [14:0] DLY_HOP     = 15'd3550;
  localparam logic [14:0] DLY_HOP_END = 15'd13900;

  // Number of rows in the SOP code table.
  localparam logic [7:0] SOP_ROWS = 8'd19;

  // Reset value of the hop channels.
  localparam logic [6:0] HOP_RESET = 7'd8;

endpackage

@@ hw/rtl/rclh_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclh_regs
// APB-style configuration registers: device id and the three hop channels.
// Registers sit at eight-byte spacing; the port never stalls.
// ----------------------------------------------------------------------------
module rclh_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output rclh_pkg::cfg_t cfg
);
  import rclh_pkg::*;

  reg_index_t index;
  logic       wr_en;

  // Register index comes from the upper address bits.
  assign index  = reg_index_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase of a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_id     <= '0;
      cfg.hop_channel_a <= HOP_RESET;
      cfg.hop_channel_b <= HOP_RESET;
      cfg.hop_channel_c <= HOP_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_DEVICE_ID: cfg.device_id     <= pwdata[47:0];
        REG_HOP_A:     cfg.hop_channel_a <= pwdata[6:0];
        REG_HOP_B:     cfg.hop_channel_b <= pwdata[6:0];
        REG_HOP_C:     cfg.hop_channel_c <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read-back of the selected register.
  always_comb begin
    unique case (index)
      REG_DEVICE_ID: prdata = {16'd0, cfg.device_id};
      REG_HOP_A:     prdata = {57'd0, cfg.hop_channel_a};
      REG_HOP_B:     prdata = {57'd0, cfg.hop_channel_b};
      REG_HOP_C:     prdata = {57'd0, cfg.hop_channel_c};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rclh_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclh_step
// Phase register and combinational decode of one timer event into a radio
// command, including the bind reply check and the link code derivation.
// ----------------------------------------------------------------------------
module rclh_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rclh_pkg::evt_item_t evt,
  input  rclh_pkg::cfg_t      cfg,
  output logic                has_result,
  output rclh_pkg::cmd_item_t cmd
);
  import rclh_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic        reply_ok;
  logic [7:0]  b0, b1, b2, b3, b4, b5;
  logic [7:0]  sop_sum;
  logic [4:0]  sop_quot;
  logic [7:0]  sop_sub;
  logic [7:0]  seed_lo;
  logic [7:0]  seed_hi;

  // Bind reply check against the configured id.
  assign reply_ok = ((evt.rx_irq_status & RX_STATUS_MASK) == RX_STATUS_MASK) &&
                    (evt.rx_length == RX_BIND_LEN) && (evt.rx_count == RX_BIND_LEN) &&
                    (evt.rx_type == RX_BIND_TYPE) && (evt.rx_id == cfg.device_id);

  // Link codes from the id bytes, all sums modulo 256.
  assign b0 = cfg.device_id[7:0];
  assign b1 = cfg.device_id[15:8];
  assign b2 = cfg.device_id[23:16];
  assign b3 = cfg.device_id[31:24];
  assign b4 = cfg.device_id[39:32];
  assign b5 = cfg.device_id[47:40];
  assign sop_sum = 8'(b0 + b1 + b2 + b3 - b5);
  assign seed_lo = 8'(b1 - b4 + b5);
  assign seed_hi = 8'(b2 + b3 - b4 + b5);

  // Remainder by 19: the quotient of an 8-bit value is exactly (x * 27) >> 9.
  assign sop_quot = 5'((16'(sop_sum) * 16'd27) >> 9);
  assign sop_sub  = 8'({3'd0, sop_quot} * SOP_ROWS);

  // Phase register advances once per processed event.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BIND_START;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  // Next phase.
  always_comb begin
    unique case (phase) inside
      PH_BIND_START, PH_BIND_SEND, PH_SPARE: phase_next = PH_WAIT_TX;
      PH_WAIT_TX: phase_next = evt.tx_done ? PH_CHECK : PH_WAIT_TX;
      PH_CHECK:   phase_next = reply_ok ? PH_ACK0 : PH_BIND_SEND;
      PH_ACK0, PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4, PH_ACK5:
        phase_next = phase_t'(4'(phase) + 4'd1);
      PH_LINK:    phase_next = PH_HOP0;
      PH_HOP0:    phase_next = PH_HOP1;
      PH_HOP1:    phase_next = PH_HOP2;
      PH_HOP2:    phase_next = PH_HOP3;
      PH_HOP3:    phase_next = PH_HOP0;
      default:    phase_next = PH_BIND_START;
    endcase
  end

  // Command for the current phase.
  always_comb begin
    has_result = 1'b1;
    cmd        = '0;
    unique case (phase) inside
      PH_BIND_START, PH_BIND_SEND, PH_SPARE: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = CH_BIND_TX;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_BIND;
        cmd.next_delay_us = DLY_BIND_TX;
      end
      PH_WAIT_TX: begin
        has_result        = evt.tx_done;
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = CH_BIND_RX;
        cmd.radio_mode    = MODE_RX;
        cmd.next_delay_us = DLY_LISTEN;
      end
      PH_CHECK: begin
        if (reply_ok) begin
          cmd.set_channel   = 1'b1;
          cmd.rf_channel    = CH_ACK;
          cmd.radio_mode    = MODE_TX;
          cmd.next_delay_us = DLY_ACK_GO;
        end else begin
          cmd.next_delay_us = DLY_RETRY;
        end
      end
      PH_ACK0, PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4, PH_ACK5: begin
        cmd.send_kind     = KIND_ACK;
        cmd.next_delay_us = DLY_ACK;
      end
      PH_LINK: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = cfg.hop_channel_a;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_DATA;
        cmd.refresh_data  = 1'b1;
        cmd.load_link     = 1'b1;
        cmd.sop_index     = 5'(sop_sum - sop_sub);
        cmd.crc_seed      = {seed_hi, seed_lo};
        cmd.next_delay_us = DLY_HOP;
      end
      PH_HOP0: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = cfg.hop_channel_a;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_DATA;
        cmd.refresh_data  = 1'b1;
        cmd.next_delay_us = DLY_HOP;
      end
      PH_HOP1: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = cfg.hop_channel_b;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_DATA;
        cmd.next_delay_us = DLY_HOP;
      end
      PH_HOP2: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = cfg.hop_channel_c;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_DATA;
        cmd.next_delay_us = DLY_HOP;
      end
      PH_HOP3: begin
        cmd.set_channel   = 1'b1;
        cmd.rf_channel    = cfg.hop_channel_a;
        cmd.radio_mode    = MODE_TX;
        cmd.send_kind     = KIND_DATA;
        cmd.next_delay_us = DLY_HOP_END;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // The reply check never leaves the phase in place.
  a_check_leaves: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_CHECK |=> phase == PH_ACK0 || phase == PH_BIND_SEND)
    else $error("reply check did not move to ack or retry");

  // Waiting for transmit done only holds while tx_done is low.
  a_wait_tx: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_WAIT_TX && !evt.tx_done |=> phase == PH_WAIT_TX)
    else $error("left transmit wait without tx_done");

endmodule

@@ hw/rtl/rc_link_bind_and_hop_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_bind_and_hop_sequencer
// Link-layer sequencer for a 2.4 GHz remote-control transmitter: bind
// handshake, ack burst, link code load and channel hopping.
// ----------------------------------------------------------------------------
// Each event transaction is one timer expiry. It is captured in an input
// register, decoded combinationally against the phase register, and the
// resulting radio command lands in the command register. One event is
// accepted every cycle while the command side keeps up; evt_ready follows
// cmd_ready combinationally when both registers are full. An event in the
// transmit wait phase with tx_done low gives no command. Configuration is
// written through the APB port with no wait states; the user must write it
// only while the block is idle, which the block itself does not enforce.
module rc_link_bind_and_hop_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  input  rclh_pkg::evt_item_t evt,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output rclh_pkg::cmd_item_t cmd,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import rclh_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  evt_item_t s1_item;
  logic      advance;
  logic      fire;
  logic      has_result;
  cmd_item_t cmd_next;

  // Configuration registers.
  rclh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow: the input stage moves whenever the command register frees.
  assign advance   = !cmd_valid || cmd_ready;
  assign fire      = s1_valid && advance;
  assign evt_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_ready) begin
      s1_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      s1_item <= evt;
    end
  end

  // Phase register and command decode.
  rclh_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .evt        (s1_item),
    .cfg        (cfg),
    .has_result (has_result),
    .cmd        (cmd_next)
  );

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      cmd <= cmd_next;
    end
  end

  // A stalled input stage keeps its event.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input stage lost or changed a stalled event");

  // Link load always comes with a data packet on a programmed channel.
  a_link_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.load_link |-> cmd.set_channel && cmd.send_kind == KIND_DATA)
    else $error("link load without data packet on a channel");

  // Unprogrammed channel and unloaded link codes read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.set_channel || cmd.rf_channel == '0) &&
                  (cmd.load_link || (cmd.sop_index == '0 && cmd.crc_seed == '0)))
    else $error("inactive command fields not zero");

endmodule
